### rtl/rabs_pkg.sv
// Shared types and constants of the running-average background subtractor.
// Depends on nothing; every design module imports it.
package rabs_pkg;

   // Gray conversion weights, Q14
   localparam logic [13:0] GRAY_COEF_R = 14'd4899;
   localparam logic [13:0] GRAY_COEF_G = 14'd9617;
   localparam logic [13:0] GRAY_COEF_B = 14'd1868;
   localparam logic [21:0] GRAY_ROUND  = 22'd8192;

   // Blend rounding and unity for alpha in Q1.8
   localparam logic [16:0] BLEND_ROUND = 17'd128;
   localparam logic [8:0]  ALPHA_ONE   = 9'd256;

   // Register widths and reset values
   localparam int          CSR_DATA_W   = 17;
   localparam int          CSR_INDEX_W  = 2;
   localparam logic [8:0]  ALPHA_RESET  = 9'd51;
   localparam logic [7:0]  THRESH_RESET = 8'd30;
   localparam logic [16:0] FRAME_RESET  = 17'd65536;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME  = 2'd2;

   // Command queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified pixel as handed from the front to the back
   typedef struct packed {
      logic [7:0] gray;
      logic       update;
      logic       last;
   } pix_cmd_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM
   } back_state_type;

endpackage

### rtl/rabs_if.sv
// Channel interfaces of the background subtractor: pixel request and result.
// Depends on nothing.
interface rabs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, blue, green, red, input ready);
   modport sink (input valid, blue, green, red, output ready);
endinterface

interface rabs_rsp_if;
   logic       valid;
   logic       ready;
   logic       foreground;
   logic [7:0] background_gray;
   logic       frame_end;

   modport source (output valid, foreground, background_gray, frame_end, input ready);
   modport sink (input valid, foreground, background_gray, frame_end, output ready);
endinterface

### rtl/running_average_background_subtractor_unit.sv
// Running-average background subtractor: one BGR pixel per request beat, in raster
// order. The first frame only fills the background store and gives no result beat;
// each pixel of later frames updates its background entry and gives one result beat
// with the foreground flag, the new background gray and a frame-end mark. A priming
// pixel is written straight to the store; an updating pixel passes store read,
// multiply, and sum with write-back, a read-modify-write sequence on the single
// background store port. The front end converts pixels combinationally and keeps
// accepting while a two-entry queue has room. The store needs no clearing pass after
// reset. Depends on rabs_pkg, rabs_if, rabs_front, rabs_queue and rabs_back.
module running_average_background_subtractor_unit
   import rabs_pkg::*;
#(
   parameter int MAX_PIXELS = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   rabs_req_if.sink               req_chan,
   rabs_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int QW = $bits(pix_cmd_type) + AW;

   logic [8:0]    alpha_ff;
   logic [7:0]    thresh_ff;
   logic [16:0]   frame_ff;

   logic          q_push, q_pop, q_full, q_empty;
   pix_cmd_type   front_cmd, back_cmd;
   logic [AW-1:0] front_addr, back_addr;
   logic [QW-1:0] q_wdata, q_rdata;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         thresh_ff <= THRESH_RESET;
         frame_ff  <= FRAME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA:  alpha_ff  <= csr_wdata[8:0];
            CSR_THRESH: thresh_ff <= csr_wdata[7:0];
            CSR_FRAME:  frame_ff  <= csr_wdata[16:0];
            default:    frame_ff  <= frame_ff;
         endcase
      end
   end

   rabs_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .frame_pixels (frame_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (front_cmd),
      .q_addr       (front_addr)
   );

   assign q_wdata = {front_cmd, front_addr};

   rabs_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   assign back_cmd  = pix_cmd_type'(q_rdata[QW-1:AW]);
   assign back_addr = q_rdata[AW-1:0];

   rabs_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_cmd        (back_cmd),
      .q_addr       (back_addr),
      .alpha_q8     (alpha_ff),
      .fg_threshold (thresh_ff),
      .rsp_chan     (rsp_chan)
   );

   // The front end never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // The back end never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   // A new result beat appears only after a queued pixel was popped.
   a_result_follows_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!q_empty, 3))
      else $error("result beat without a queued pixel");

endmodule

### rtl/rabs_front.sv
// Front end: accepts pixel beats, converts them to gray and tracks frame position.
// Depends on rabs_pkg and rabs_req_if.
module rabs_front
   import rabs_pkg::*;
#(
   parameter int MAX_PIXELS = 65536,
   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   rabs_req_if.sink         req_chan,
   input  logic [16:0]      frame_pixels,
   input  logic             q_full,
   output logic             q_push,
   output pix_cmd_type      q_cmd,
   output logic [AW-1:0]    q_addr
);

   localparam int LW = $clog2(MAX_PIXELS + 1);
   localparam int CW = (LW > 17) ? LW : 17;

   logic [AW-1:0] pos_ff, pos_in;
   logic          primed_ff, primed_in;
   logic [CW-1:0] len_raw, len_eff, pos_inc;
   logic [21:0]   gray_sum;
   logic          last;

   // A beat is taken whenever the queue has room.
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   // Weighted sum of the three channels, rounded, Q14.
   assign gray_sum = 22'(req_chan.red) * 22'(GRAY_COEF_R)
                   + 22'(req_chan.green) * 22'(GRAY_COEF_G)
                   + 22'(req_chan.blue) * 22'(GRAY_COEF_B)
                   + GRAY_ROUND;

   // Frame length clamped into one through the store depth.
   always_comb begin
      len_raw = CW'(frame_pixels);
      if (len_raw == '0) begin
         len_eff = CW'(1);
      end else if (len_raw > CW'(MAX_PIXELS)) begin
         len_eff = CW'(MAX_PIXELS);
      end else begin
         len_eff = len_raw;
      end
      pos_inc = CW'(pos_ff) + CW'(1);
      last    = (pos_inc >= len_eff);
   end

   assign q_cmd.gray   = gray_sum[21:14];
   assign q_cmd.update = primed_ff;
   assign q_cmd.last   = last;
   assign q_addr       = pos_ff;

   // Position wraps at the frame end; the first frame end marks the store primed.
   always_comb begin
      pos_in    = pos_ff;
      primed_in = primed_ff;
      if (q_push) begin
         if (last) begin
            pos_in    = '0;
            primed_in = 1'b1;
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         primed_ff <= primed_in;
      end
   end

endmodule

### rtl/rabs_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on rabs_pkg for its depth.
module rabs_queue
   import rabs_pkg::*;
#(
   parameter int WIDTH = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rabs_back.sv
// Back end: owns the background store, blends each updating pixel and drives result beats.
// Depends on rabs_pkg and rabs_rsp_if.
module rabs_back
   import rabs_pkg::*;
#(
   parameter int MAX_PIXELS = 65536,
   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   output logic             q_pop,
   input  pix_cmd_type      q_cmd,
   input  logic [AW-1:0]    q_addr,
   input  logic [8:0]       alpha_q8,
   input  logic [7:0]       fg_threshold,
   rabs_rsp_if.source       rsp_chan
);

   back_state_type state_ff, state_in;

   logic [7:0]    store [MAX_PIXELS];
   logic [7:0]    rdata_ff;
   pix_cmd_type   cmd_ff;
   logic [AW-1:0] addr_ff;
   logic [16:0]   prod_new_ff, prod_old_ff;
   logic [8:0]    alpha_eff, alpha_inv;
   logic [16:0]   blend_sum;
   logic [7:0]    new_bg, diff;

   logic          rd_en, wr_en, out_free, out_load;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          fg_ff;
   logic [7:0]    bg_ff;
   logic          end_ff;

   // Next state of the read, multiply, sum sequence.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_cmd.update) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_SUM;
         end
         BK_SUM: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Blend arithmetic on the registered products.
   always_comb begin
      alpha_eff = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
      alpha_inv = ALPHA_ONE - alpha_eff;
      blend_sum = prod_new_ff + prod_old_ff + BLEND_ROUND;
      new_bg    = blend_sum[15:8];
      diff      = (cmd_ff.gray > new_bg) ? cmd_ff.gray - new_bg : new_bg - cmd_ff.gray;
   end

   // Sequencer outputs: queue pop, store access and result load.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      out_load = 1'b0;
      wr_addr  = q_addr;
      wr_data  = q_cmd.gray;
      case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty;
            rd_en = !q_empty && q_cmd.update;
            wr_en = !q_empty && !q_cmd.update;
         end
         BK_SUM: begin
            wr_en    = out_free;
            out_load = out_free;
            wr_addr  = addr_ff;
            wr_data  = new_bg;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Background store with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store[q_addr];
      end
   end

   // Command capture and the two products.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff  <= q_cmd;
         addr_ff <= q_addr;
      end
      if (state_ff == BK_MUL) begin
         prod_new_ff <= 17'(alpha_eff) * 17'(cmd_ff.gray);
         prod_old_ff <= 17'(alpha_inv) * 17'(rdata_ff);
      end
   end

   // Result register; a new beat loads as the previous one leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         fg_ff  <= (diff > fg_threshold);
         bg_ff  <= new_bg;
         end_ff <= cmd_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.foreground      = fg_ff;
   assign rsp_chan.background_gray = bg_ff;
   assign rsp_chan.frame_end       = end_ff;

endmodule
